// ----- src/lkv_pkg.sv -----
// Shared constants and types for the LRU key-value cache.
package lkv_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BITS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 20;

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   // write and read strobes from the sequencer to the entry store
   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic value_we;
      logic rank_we;
   } store_ctl_type;

endpackage

// ----- src/lkv_channels.sv -----
// Handshake channel interfaces: request, response and capacity register write.
interface lkv_req_if #(
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

interface lkv_rsp_if #(
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkv_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lkv_pkg::CAP_BITS-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- src/lkv_store.sv -----
// Entry store: key, value and recency rank memories with registered read data.
module lkv_store #(
   parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF,
   parameter int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                   clock,
   input  lkv_pkg::store_ctl_type ctl,
   input  logic [AW-1:0]          rd_addr,
   output logic [KEY_BITS-1:0]    rd_key,
   output logic [VALUE_BITS-1:0]  rd_value,
   output logic [AW-1:0]          rd_rank,
   input  logic [AW-1:0]          wr_addr,
   input  logic [KEY_BITS-1:0]    wr_key,
   input  logic [VALUE_BITS-1:0]  wr_value,
   input  logic [AW-1:0]          rank_wr_addr,
   input  logic [AW-1:0]          rank_wr_data
);

   logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];
   logic [AW-1:0]         rank_mem  [ENTRIES];

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.value_we) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (ctl.rank_we) begin
         rank_mem[rank_wr_addr] <= rank_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_key   <= key_mem[rd_addr];
         rd_value <= value_mem[rd_addr];
         rd_rank  <= rank_mem[rd_addr];
      end
   end

endmodule

// ----- src/lkv_ctrl.sv -----
// Sequencer: search occupied slots, then recency update unless a get misses.
module lkv_ctrl #(
   parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF,
   parameter int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lkv_pkg::CAP_BITS-1:0] capacity,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [KEY_BITS-1:0]          req_key,
   input  logic [VALUE_BITS-1:0]        req_value,
   output logic                         res_valid,
   input  logic                         res_ready,
   output logic                         res_hit,
   output logic [VALUE_BITS-1:0]        res_value,
   output lkv_pkg::store_ctl_type       ctl,
   output logic [AW-1:0]                rd_addr,
   input  logic [KEY_BITS-1:0]          rd_key,
   input  logic [VALUE_BITS-1:0]        rd_value,
   input  logic [AW-1:0]                rd_rank,
   output logic [AW-1:0]                wr_addr,
   output logic [KEY_BITS-1:0]          wr_key,
   output logic [VALUE_BITS-1:0]        wr_value,
   output logic [AW-1:0]                rank_wr_addr,
   output logic [AW-1:0]                rank_wr_data
);

   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff,     state_in;
   logic                  action_ff,    action_in;
   logic [KEY_BITS-1:0]   key_ff,       key_in;
   logic [VALUE_BITS-1:0] value_ff,     value_in;
   logic [CW-1:0]         rd_idx_ff,    rd_idx_in;
   logic                  rd_pend_ff,   rd_pend_in;
   logic [AW-1:0]         pend_idx_ff,  pend_idx_in;
   logic                  found_ff,     found_in;
   logic [AW-1:0]         slot_ff,      slot_in;
   logic [CW-1:0]         old_rank_ff,  old_rank_in;
   logic [AW-1:0]         lru_slot_ff,  lru_slot_in;
   logic [VALUE_BITS-1:0] hit_value_ff, hit_value_in;
   logic                  ins_ff,       ins_in;
   logic [CW-1:0]         occ_ff,       occ_in;

   logic        more;
   logic        pass_done;
   logic [31:0] cap_w;
   logic [31:0] eff_w;
   logic        evict;

   assign more      = rd_idx_ff < occ_ff;
   assign pass_done = !more && !rd_pend_ff;

   // capacity zero acts as one, above the store size as the store size
   assign cap_w = 32'(capacity);
   assign eff_w = (cap_w == 32'd0) ? 32'd1 :
                  ((cap_w > 32'(ENTRIES)) ? 32'(ENTRIES) : cap_w);
   assign evict = 32'(occ_ff) >= eff_w;

   assign res_hit   = found_ff;
   assign res_value = found_ff ? hit_value_ff : '0;
   assign wr_key    = key_ff;
   assign wr_value  = value_ff;
   assign rd_addr   = rd_idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = rd_pend_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      old_rank_in  = old_rank_ff;
      lru_slot_in  = lru_slot_ff;
      hit_value_in = hit_value_ff;
      ins_in       = ins_ff;
      occ_in       = occ_ff;
      ctl          = '0;
      wr_addr      = slot_ff;
      rank_wr_addr = pend_idx_ff;
      rank_wr_data = '0;
      req_ready    = 1'b0;
      res_valid    = 1'b0;

      if (state_ff == ST_SEARCH || state_ff == ST_UPDATE) begin
         ctl.rd_en   = more;
         rd_idx_in   = more ? rd_idx_ff + CW'(1) : rd_idx_ff;
         rd_pend_in  = more;
         pend_idx_in = rd_idx_ff[AW-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in  = req_action;
               key_in     = req_key;
               value_in   = req_value;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               found_in   = 1'b0;
               ins_in     = 1'b0;
               state_in   = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (rd_pend_ff) begin
               if (!found_ff && rd_key == key_ff) begin
                  found_in     = 1'b1;
                  slot_in      = pend_idx_ff;
                  old_rank_in  = CW'(rd_rank);
                  hit_value_in = rd_value;
               end
               if (CW'(rd_rank) == occ_ff - CW'(1)) begin
                  lru_slot_in = pend_idx_ff;
               end
            end
            if (pass_done) begin
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               if (action_ff == lkv_pkg::ACT_GET) begin
                  state_in = found_ff ? ST_UPDATE : ST_FINISH;
               end else if (found_ff) begin
                  ctl.value_we = 1'b1;
                  state_in     = ST_UPDATE;
               end else if (evict) begin
                  // reuse the least recent slot
                  ctl.key_we   = 1'b1;
                  ctl.value_we = 1'b1;
                  wr_addr      = lru_slot_ff;
                  slot_in      = lru_slot_ff;
                  old_rank_in  = occ_ff - CW'(1);
                  state_in     = ST_UPDATE;
               end else begin
                  // fill the next free slot; every occupied entry ages by one
                  ctl.key_we   = 1'b1;
                  ctl.value_we = 1'b1;
                  ctl.rank_we  = 1'b1;
                  wr_addr      = occ_ff[AW-1:0];
                  rank_wr_addr = occ_ff[AW-1:0];
                  slot_in      = occ_ff[AW-1:0];
                  old_rank_in  = occ_ff;
                  ins_in       = 1'b1;
                  state_in     = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (rd_pend_ff) begin
               ctl.rank_we = 1'b1;
               if (pend_idx_ff == slot_ff) begin
                  rank_wr_data = '0;
               end else if (CW'(rd_rank) < old_rank_ff) begin
                  rank_wr_data = rd_rank + AW'(1);
               end else begin
                  rank_wr_data = rd_rank;
               end
            end
            if (pass_done) begin
               if (ins_ff) begin
                  occ_in = occ_ff + CW'(1);
               end
               ins_in   = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (action_ff == lkv_pkg::ACT_GET) begin
               res_valid = 1'b1;
               if (res_ready) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         occ_ff     <= '0;
         rd_pend_ff <= 1'b0;
         ins_ff     <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         occ_ff     <= occ_in;
         rd_pend_ff <= rd_pend_in;
         ins_ff     <= ins_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      rd_idx_ff    <= rd_idx_in;
      pend_idx_ff  <= pend_idx_in;
      slot_ff      <= slot_in;
      old_rank_ff  <= old_rank_in;
      lru_slot_ff  <= lru_slot_in;
      hit_value_ff <= hit_value_in;
   end

endmodule

// ----- src/lru_key_value_cache_core.sv -----
// Top level of the LRU key-value cache: channels, capacity register, response register.
//
// Fully associative key-value cache with least-recently-used replacement.
// req_chan carries one beat per operation: action (get or put), key, value.
// rsp_chan returns one beat per get: hit and the stored value (zero on a miss);
// a put returns nothing. csr_chan writes the capacity register; it is always
// ready. The user must write it only while the block is idle; the block itself
// does not enforce it. Each operation makes a search pass over the occupied
// slots and, unless it is a missing get, a recency update pass; both run through
// the single read port of the entry store, one slot per cycle. req_chan is
// ready only while no operation is in progress, so the block takes no new
// request beat before it is through with the last one.
// The response sits in an output register: the next request is taken while it
// waits, and a later get holds at its end until the register is free.
// Reset (synchronous) empties the cache and sets capacity to 16; no clearing
// pass is needed, so the block is ready in the cycle after reset.
module lru_key_value_cache_core #(
   parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
   parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lkv_req_if.sink   req_chan,
   lkv_rsp_if.source rsp_chan,
   lkv_csr_if.sink   csr_chan
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [lkv_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0]        rsp_value_ff, rsp_value_in;

   logic                   res_valid;
   logic                   res_ready;
   logic                   res_hit;
   logic [VALUE_BITS-1:0]  res_value;
   lkv_pkg::store_ctl_type ctl;
   logic [AW-1:0]          rd_addr;
   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_value;
   logic [AW-1:0]          rd_rank;
   logic [AW-1:0]          wr_addr;
   logic [KEY_BITS-1:0]    wr_key;
   logic [VALUE_BITS-1:0]  wr_value;
   logic [AW-1:0]          rank_wr_addr;
   logic [AW-1:0]          rank_wr_data;

   assign csr_chan.ready = 1'b1;
   assign cap_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : cap_ff;

   // output register frees when empty or when its beat is taken
   assign res_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = (res_valid && res_ready) ||
                         (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_hit_in   = (res_valid && res_ready) ? res_hit : rsp_hit_ff;
   assign rsp_value_in = (res_valid && res_ready) ? res_value : rsp_value_ff;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lkv_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   lkv_ctrl #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .AW         (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .capacity     (cap_ff),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_action   (req_chan.action),
      .req_key      (req_chan.key),
      .req_value    (req_chan.value),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_hit      (res_hit),
      .res_value    (res_value),
      .ctl          (ctl),
      .rd_addr      (rd_addr),
      .rd_key       (rd_key),
      .rd_value     (rd_value),
      .rd_rank      (rd_rank),
      .wr_addr      (wr_addr),
      .wr_key       (wr_key),
      .wr_value     (wr_value),
      .rank_wr_addr (rank_wr_addr),
      .rank_wr_data (rank_wr_data)
   );

   lkv_store #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .AW         (AW)
   ) u_store (
      .clock        (clock),
      .ctl          (ctl),
      .rd_addr      (rd_addr),
      .rd_key       (rd_key),
      .rd_value     (rd_value),
      .rd_rank      (rd_rank),
      .wr_addr      (wr_addr),
      .wr_key       (wr_key),
      .wr_value     (wr_value),
      .rank_wr_addr (rank_wr_addr),
      .rank_wr_data (rank_wr_data)
   );

endmodule
